@@ rtl/plb_pkg.sv @@
// shared types and constants for the positional list buffer
package plb_pkg;

    localparam int IDX_W  = 6;
    localparam int DATA_W = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_PRINT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_INSERT = 2'd1,
        CM_DELETE = 2'd2,
        CM_ROTATE = 2'd3
    } t_cell_mode;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SCAN = 2'd2
    } t_state;

    // idx is the target slot for insert/delete, the last occupied slot for rotate
    typedef struct packed {
        t_cell_mode             mode;
        logic [IDX_W-1:0]       idx;
        logic [DATA_W-1:0]      element;
    } t_cell_cmd;

endpackage

@@ rtl/positional_list_buffer_core.sv @@
// positional list buffer top level: control, output register and cell chain
// insert, delete and rejected items: the exec state registers the result once the output is free,
// then returns to idle, where the next item is accepted
// valid get, non-empty print: occupied cells rotate once, a step per cycle unless output stalls
// print gives one result per cycle while the output is taken; next item accepted after the rotation
// reset clears list length, state and output valid; entry contents are undefined until written
module positional_list_buffer_core
    import plb_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_operation,
    input  logic [IDX_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_element,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_element_out,
    output logic              o_element_valid,
    output logic [1:0]        o_status,
    output logic              o_last
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    t_op               r_op;
    logic [IDX_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_elem;

    logic              r_ov, n_ov;
    logic [DATA_W-1:0] r_oelem, n_oelem;
    logic              r_oevalid, n_oevalid;
    t_status           r_ostatus, n_ostatus;
    logic              r_olast, n_olast;

    t_cell_cmd         w_cmd;
    logic              w_accept;
    logic              w_out_free;
    logic [CMP_W-1:0]  w_pos_ext;
    logic [CMP_W-1:0]  w_len_ext;
    logic [IDX_W-1:0]  w_pos_idx;
    logic [IDX_W-1:0]  w_last_idx;
    logic              w_ins_bad;
    logic              w_rd_bad;
    logic              w_emit;
    logic [DATA_W-1:0] w_data [CAPACITY];

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ov || i_ready;
    assign w_pos_ext  = CMP_W'(r_pos);
    assign w_len_ext  = CMP_W'(r_len);
    assign w_pos_idx  = r_pos - IDX_W'(1);
    assign w_last_idx = IDX_W'(r_len - LEN_W'(1));
    assign w_ins_bad  = (r_pos == '0) || (w_pos_ext > (w_len_ext + CMP_W'(1)));
    assign w_rd_bad   = (r_pos == '0) || (w_pos_ext > w_len_ext);
    assign w_emit     = (r_op == OP_PRINT) || (r_cnt == w_pos_idx);

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= t_op'(i_operation);
            r_pos  <= i_position;
            r_elem <= i_element;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oelem   <= n_oelem;
        r_oevalid <= n_oevalid;
        r_ostatus <= n_ostatus;
        r_olast   <= n_olast;
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_ov      = r_ov && !i_ready;
        n_oelem   = r_oelem;
        n_oevalid = r_oevalid;
        n_ostatus = r_ostatus;
        n_olast   = r_olast;
        w_cmd     = '{mode: CM_HOLD, idx: w_pos_idx, element: r_elem};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_ov      = 1'b1;
                    n_oelem   = '0;
                    n_oevalid = 1'b0;
                    n_ostatus = ST_OK;
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                    n_cnt     = '0;
                    case (r_op)
                        OP_INSERT: begin
                            if (w_ins_bad) begin
                                n_ostatus = ST_INVALID;
                            end else if (r_len == LEN_W'(CAPACITY)) begin
                                n_ostatus = ST_FULL;
                            end else begin
                                w_cmd.mode = CM_INSERT;
                                n_len      = r_len + LEN_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (w_rd_bad) begin
                                n_ostatus = ST_INVALID;
                            end else begin
                                w_cmd.mode = CM_DELETE;
                                n_len      = r_len - LEN_W'(1);
                            end
                        end
                        OP_GET: begin
                            if (w_rd_bad) begin
                                n_ostatus = ST_INVALID;
                            end else begin
                                n_ov    = r_ov && !i_ready;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            if (r_len != '0) begin
                                n_ov    = r_ov && !i_ready;
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!w_emit || w_out_free) begin
                    w_cmd.mode = CM_ROTATE;
                    w_cmd.idx  = w_last_idx;
                    n_cnt      = r_cnt + IDX_W'(1);
                    if (w_emit) begin
                        n_ov      = 1'b1;
                        n_oelem   = w_data[0];
                        n_oevalid = 1'b1;
                        n_ostatus = ST_OK;
                        n_olast   = (r_op == OP_PRINT) ? (r_cnt == w_last_idx) : 1'b1;
                    end
                    if (r_cnt == w_last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_final
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        plb_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    assign o_valid         = r_ov;
    assign o_element_out   = r_oelem;
    assign o_element_valid = r_oevalid;
    assign o_status        = r_ostatus;
    assign o_last          = r_olast;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_scan_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_len))
        else $error("list length changed during rotation");

    a_scan_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= w_last_idx) && (r_len != '0))
        else $error("rotation count past last entry");
`endif

endmodule

@@ rtl/plb_cell.sv @@
// one storage cell of the list chain
module plb_cell
    import plb_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    input  logic [DATA_W-1:0] i_head,
    output logic [DATA_W-1:0] o_data
);

    localparam logic [IDX_W-1:0] L_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.mode)
            CM_INSERT: begin
                if (L_IDX > i_cmd.idx) begin
                    n_data = i_left;
                end else if (L_IDX == i_cmd.idx) begin
                    n_data = i_cmd.element;
                end
            end
            CM_DELETE: begin
                if (L_IDX >= i_cmd.idx) begin
                    n_data = i_right;
                end
            end
            CM_ROTATE: begin
                if (L_IDX < i_cmd.idx) begin
                    n_data = i_right;
                end else if (L_IDX == i_cmd.idx) begin
                    n_data = i_head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ dv/positional_list_buffer_checker.sv @@
// checker for the positional list buffer: list prediction and result comparison
module positional_list_buffer_checker
    import plb_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [1:0]        i_operation,
    input  logic [IDX_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_element,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  logic [DATA_W-1:0] i_element_out,
    input  logic              i_element_valid,
    input  logic [1:0]        i_status,
    input  logic              i_last,
    output int                o_mismatch_count,
    output int                o_outstanding
);

    typedef struct packed {
        logic [DATA_W-1:0] element;
        logic              element_valid;
        t_status           status;
        logic              last;
    } t_list_result;

    logic [DATA_W-1:0] list_bytes [CAPACITY];
    int                list_len;
    t_list_result      results_due [$];
    t_list_result      want_result;
    int                mismatches;

    initial begin
        list_len         = 0;
        mismatches       = 0;
        o_mismatch_count = 0;
        o_outstanding    = 0;
    end

    task automatic push_result(input logic [DATA_W-1:0] elem, input logic elem_valid,
                               input t_status st, input logic is_last);
        t_list_result res;
        res.element       = elem;
        res.element_valid = elem_valid;
        res.status        = st;
        res.last          = is_last;
        results_due.push_back(res);
    endtask

    task automatic predict_list_op(input t_op op, input logic [IDX_W-1:0] pos,
                                   input logic [DATA_W-1:0] elem);
        int p;
        int idx;
        p = int'(pos);
        case (op)
            OP_INSERT: begin
                if (p == 0 || p > list_len + 1) begin
                    push_result('0, 1'b0, ST_INVALID, 1'b1);
                end else if (list_len >= CAPACITY) begin
                    push_result('0, 1'b0, ST_FULL, 1'b1);
                end else begin
                    for (idx = list_len; idx >= p; idx--)
                        list_bytes[idx] = list_bytes[idx-1];
                    list_bytes[p-1] = elem;
                    list_len++;
                    push_result('0, 1'b0, ST_OK, 1'b1);
                end
            end
            OP_DELETE: begin
                if (p == 0 || p > list_len) begin
                    push_result('0, 1'b0, ST_INVALID, 1'b1);
                end else begin
                    for (idx = p; idx < list_len; idx++)
                        list_bytes[idx-1] = list_bytes[idx];
                    list_len--;
                    push_result('0, 1'b0, ST_OK, 1'b1);
                end
            end
            OP_GET: begin
                if (p == 0 || p > list_len)
                    push_result('0, 1'b0, ST_INVALID, 1'b1);
                else
                    push_result(list_bytes[p-1], 1'b1, ST_OK, 1'b1);
            end
            default: begin
                if (list_len == 0)
                    push_result('0, 1'b0, ST_OK, 1'b1);
                else
                    for (idx = 0; idx < list_len; idx++)
                        push_result(list_bytes[idx], 1'b1, ST_OK, idx + 1 == list_len);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            results_due.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                predict_list_op(t_op'(i_operation), i_position, i_element);
            if (i_rsp_valid && i_rsp_ready) begin
                if (results_due.size() == 0) begin
                    if (mismatches < 10)
                        $display(
                            "%0t unexpected transaction: element %h valid %b status %0d last %b",
                            $realtime, i_element_out, i_element_valid, i_status, i_last);
                    mismatches++;
                end else begin
                    want_result = results_due.pop_front();
                    if (i_element_out !== want_result.element ||
                        i_element_valid !== want_result.element_valid ||
                        i_status !== want_result.status ||
                        i_last !== want_result.last) begin
                        if (mismatches < 10)
                            $display("%0t mismatch: expected %h %b %0d %b, got %h %b %0d %b",
                                     $realtime, want_result.element, want_result.element_valid,
                                     want_result.status, want_result.last, i_element_out,
                                     i_element_valid, i_status, i_last);
                        mismatches++;
                    end
                end
            end
        end
        o_outstanding    <= results_due.size();
        o_mismatch_count <= mismatches;
    end

endmodule

@@ dv/positional_list_buffer_core_test.sv @@
// testbench top for the positional list buffer: stimulus, flow control and verdict
module positional_list_buffer_core_test;
    import plb_pkg::*;

    localparam int CAPACITY  = 32;
    localparam int LONG_HOLD = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_operation;
    logic [IDX_W-1:0]  i_position;
    logic [DATA_W-1:0] i_element;
    logic              o_valid;
    logic              i_ready;
    logic [DATA_W-1:0] o_element_out;
    logic              o_element_valid;
    logic [1:0]        o_status;
    logic              o_last;

    int mismatch_count;
    int outstanding;
    int send_idle_pct;
    int rsp_stall_pct;
    int hold_requests;
    int list_fill;

    positional_list_buffer_core #(.CAPACITY(CAPACITY)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_position      (i_position),
        .i_element       (i_element),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_element_out   (o_element_out),
        .o_element_valid (o_element_valid),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    positional_list_buffer_checker #(.CAPACITY(CAPACITY)) list_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_element        (i_element),
        .i_rsp_valid      (o_valid),
        .i_rsp_ready      (i_ready),
        .i_element_out    (o_element_out),
        .i_element_valid  (o_element_valid),
        .i_status         (o_status),
        .i_last           (o_last),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("** positional_list_buffer_core: FAILED **");
        $finish;
    end

    // result side: random stalls plus an occasional long hold-off
    initial begin
        int hold_left;
        int hold_served;
        i_ready     = 1'b0;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    task automatic offer_item(input t_op op, input logic [IDX_W-1:0] pos,
                              input logic [DATA_W-1:0] elem);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_element   <= elem;
        do @(posedge i_clk); while (!o_ready);
        if (op == OP_INSERT && pos != 0 && pos <= list_fill + 1 && list_fill < CAPACITY)
            list_fill++;
        else if (op == OP_DELETE && pos != 0 && pos <= list_fill)
            list_fill--;
    endtask

    task automatic random_items(input int count, input int grow_pct, input int shrink_pct);
        t_op              op;
        int               r;
        int               hi;
        logic [IDX_W-1:0] pos;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < grow_pct)
                op = OP_INSERT;
            else if (r < grow_pct + shrink_pct)
                op = OP_DELETE;
            else if ($urandom_range(99) < 70)
                op = OP_GET;
            else
                op = OP_PRINT;
            hi = (op == OP_INSERT) ? list_fill + 1 : list_fill;
            if (hi < 1)
                hi = 1;
            r = $urandom_range(99);
            if (r < 6)
                pos = '0;
            else if (r < 20)
                pos = IDX_W'($urandom_range(63));
            else
                pos = IDX_W'($urandom_range(hi, 1));
            offer_item(op, pos, DATA_W'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_operation   = OP_INSERT;
        i_position    = '0;
        i_element     = '0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_requests = 0;
        list_fill     = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, position zero, range edges, field extremes
        offer_item(OP_PRINT,  6'd0,  8'h00);
        offer_item(OP_GET,    6'd1,  8'h00);
        offer_item(OP_DELETE, 6'd1,  8'h00);
        offer_item(OP_INSERT, 6'd0,  8'h11);
        offer_item(OP_INSERT, 6'd2,  8'h22);
        offer_item(OP_INSERT, 6'd1,  8'h00);
        offer_item(OP_INSERT, 6'd2,  8'hff);
        offer_item(OP_INSERT, 6'd1,  8'h5a);
        offer_item(OP_INSERT, 6'd4,  8'ha5);
        offer_item(OP_GET,    6'd0,  8'h00);
        offer_item(OP_GET,    6'd1,  8'h00);
        offer_item(OP_GET,    6'd4,  8'hff);
        offer_item(OP_GET,    6'd5,  8'h00);
        offer_item(OP_PRINT,  6'd63, 8'hff);
        offer_item(OP_DELETE, 6'd0,  8'h00);
        offer_item(OP_DELETE, 6'd5,  8'h00);
        offer_item(OP_DELETE, 6'd2,  8'h00);
        offer_item(OP_DELETE, 6'd63, 8'h00);
        offer_item(OP_INSERT, 6'd63, 8'h3c);
        offer_item(OP_GET,    6'd2,  8'h00);
        offer_item(OP_PRINT,  6'd0,  8'h00);

        // mostly inserts to grow the list toward full, with no idling
        random_items(60, 85, 5);

        send_idle_pct = 85;
        random_items(40, 30, 30);

        // mostly deletes to shrink the list toward empty under heavy result stalls
        send_idle_pct = 0;
        rsp_stall_pct = 85;
        random_items(60, 5, 80);
        wait_drained();

        send_idle_pct = 21;
        rsp_stall_pct = 21;
        random_items(40, 40, 25);

        // long result hold-off while items keep coming
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_requests++;
        random_items(30, 50, 10);
        wait_drained();

        random_items(10, 40, 30);
        wait_drained();
        repeat (64) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("** positional_list_buffer_core: PASSED **");
        else
            $display("** positional_list_buffer_core: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
rtl/plb_pkg.sv
rtl/plb_cell.sv
rtl/positional_list_buffer_core.sv
dv/positional_list_buffer_checker.sv
dv/positional_list_buffer_core_test.sv
